/* rtl/pse_pkg.sv */
// Shared types, constants and helpers for the postfix stack evaluator.
package pse_pkg;

  // Sizes
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Divider: Q16.16 dividend is the left operand shifted up by 16
  localparam int unsigned DIVD_W      = DATA_W + 16;
  localparam int unsigned DIV_STEPS   = DIVD_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW     = 3'd1;
  localparam logic [ST_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

  // Channel payloads
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } pse_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [ST_W-1:0]          status;
    logic                     is_final;
  } pse_rsp_t;

  // Sequencer <-> arithmetic unit
  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] result;
  } alu_rsp_t;

  // State machines
  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_RD_TOP,
    CTL_RD_NEXT,
    CTL_EXEC,
    CTL_WAIT,
    CTL_DONE
  } ctl_state_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV,
    ALU_FIN,
    ALU_DONE
  } alu_state_e;

  // Saturate a 48-bit signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [DIVD_W-1:0] v);
    logic signed [DIVD_W-1:0] max_v;
    logic signed [DIVD_W-1:0] min_v;
    max_v = 48'sh0000_7FFF_FFFF;
    min_v = 48'shFFFF_8000_0000;
    if (v > max_v) begin
      return 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      return 32'sh8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

/* rtl/pse_stack_ram.sv */
// Operand stack storage: one write port, one registered read port.
module pse_stack_ram
  import pse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ADDR_W-1:0]        waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]        raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [STACK_DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/pse_alu.sv */
// Shared arithmetic unit: saturating add/sub, multiply, bit-serial divide.
module pse_alu
  import pse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  alu_req_t                 req_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output alu_rsp_t                 rsp_o
);

  alu_state_e state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic signed [DATA_W-1:0]   res_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic                       neg_q;
  logic [DIVD_W-1:0]          quo_q;
  logic [DATA_W-1:0]          rem_q;
  logic [DATA_W-1:0]          div_q;

  logic signed [DATA_W:0]   addsub;
  logic [DATA_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic [DATA_W:0]          rem_sh;
  logic [DATA_W:0]          rem_diff;
  logic                     rem_ge;
  logic signed [DATA_W-1:0] div_res;

  // Add/subtract on sign-extended operands
  always_comb begin
    if (req_i.op == OP_SUB) begin
      addsub = {a_i[DATA_W-1], a_i} - {b_i[DATA_W-1], b_i};
    end else begin
      addsub = {a_i[DATA_W-1], a_i} + {b_i[DATA_W-1], b_i};
    end
  end

  // Operand magnitudes for the divider
  assign a_mag = a_i[DATA_W-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag = b_i[DATA_W-1] ? (~b_i + 1'b1) : b_i;

  // One restoring-division step
  assign rem_sh   = {rem_q, quo_q[DIVD_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_q});
  assign rem_diff = rem_sh - {1'b0, div_q};

  // Sign and saturate the quotient magnitude
  always_comb begin
    if (neg_q) begin
      if (quo_q > DIVD_W'(48'h0000_8000_0000)) begin
        div_res = 32'sh8000_0000;
      end else begin
        div_res = ~quo_q[DATA_W-1:0] + 1'b1;
      end
    end else begin
      if (quo_q > DIVD_W'(48'h0000_7FFF_FFFF)) begin
        div_res = 32'sh7FFF_FFFF;
      end else begin
        div_res = quo_q[DATA_W-1:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_MUL:  state_d = ALU_MUL;
            OP_DIV:  state_d = ALU_DIV;
            default: state_d = ALU_DONE;
          endcase
        end
      end
      ALU_MUL: state_d = ALU_DONE;
      ALU_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ALU_FIN;
        end
      end
      ALU_FIN:  state_d = ALU_DONE;
      ALU_DONE: state_d = ALU_IDLE;
      default:  state_d = ALU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.done   = (state_q == ALU_DONE);
    rsp_o.result = res_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ALU_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          res_q  <= sat48(DIVD_W'(addsub));
          prod_q <= a_i * b_i;
          neg_q  <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
          quo_q  <= {a_mag, 16'h0000};
          rem_q  <= '0;
          div_q  <= b_mag;
        end
      end
      ALU_MUL: begin
        // arithmetic shift rounds toward minus infinity
        res_q <= sat48(prod_q[2*DATA_W-1:16]);
      end
      ALU_DIV: begin
        if (rem_ge) begin
          rem_q <= rem_diff[DATA_W-1:0];
        end else begin
          rem_q <= rem_sh[DATA_W-1:0];
        end
        quo_q <= {quo_q[DIVD_W-2:0], rem_ge};
      end
      ALU_FIN: res_q <= div_res;
      default: ;
    endcase
  end

endmodule

/* rtl/postfix_stack_evaluator.sv */
// Postfix evaluator top level: token sequencer, operand stack and result register.
//
// Usage: each request on the in channel (in_valid_i/in_ready_o, payload
// in_req_i) is one token: push a Q16.16 value, add, subtract, multiply,
// divide or finish. Every request yields exactly one response on the out
// channel (out_valid_o/out_ready_i, payload out_rsp_o) with the value,
// a status code and a flag marking the answer to a finish token.
// One token is processed at a time; in_ready_o is low while it is worked.
// A push, or a token rejected on sight (unknown, too few operands, full
// stack), is answered without the arithmetic unit; finish stops after the
// operand reads, divide by zero at the check that follows. Divide runs
// through the shared arithmetic unit's restoring divider, one quotient
// bit per cycle over 48 bits; operands come from the stack
// RAM's single registered read port, which fetches the two operands in turn.
// A finished response sits in the output register; the next request is
// taken while it waits. A stalled receiver holds the response stable, and
// the sequencer holds one more result until the register frees up.
// Reset (rst_ni, asynchronous, active low) empties the stack and drops
// any pending response. Stack RAM contents are not cleared.
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pse_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pse_rsp_t out_rsp_o
);

  ctl_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [OP_W-1:0]  op_q;
  logic signed [DATA_W-1:0] b_q;
  pse_rsp_t res_q;
  pse_rsp_t out_q;
  logic     out_valid_q;

  logic                     in_acc;
  logic                     out_load;
  logic [CNT_W-1:0]         cnt_m1;
  logic [CNT_W-1:0]         cnt_m2;
  logic [ADDR_W-1:0]        top_addr;
  logic [ADDR_W-1:0]        next_addr;
  logic                     full;
  logic                     few;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  alu_req_t                 alu_req;
  alu_rsp_t                 alu_rsp;

  // Stack pointers
  assign cnt_m1    = count_q - 1'b1;
  assign cnt_m2    = count_q - CNT_W'(2);
  assign top_addr  = cnt_m1[ADDR_W-1:0];
  assign next_addr = cnt_m2[ADDR_W-1:0];
  assign full      = (count_q >= CNT_W'(STACK_DEPTH));
  assign few       = (count_q < CNT_W'(2));

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = (state_q == CTL_DONE) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.operation)
            OP_PUSH:   state_d = CTL_DONE;
            OP_FINISH: state_d = (count_q == '0) ? CTL_DONE : CTL_RD_TOP;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_d = few ? CTL_DONE : CTL_RD_TOP;
            default:   state_d = CTL_DONE;
          endcase
        end
      end
      CTL_RD_TOP:  state_d = CTL_RD_NEXT;
      CTL_RD_NEXT: state_d = (op_q == OP_FINISH) ? CTL_DONE : CTL_EXEC;
      CTL_EXEC: begin
        if (op_q == OP_DIV && b_q == '0) begin
          state_d = CTL_DONE;
        end else begin
          state_d = CTL_WAIT;
        end
      end
      CTL_WAIT: begin
        if (alu_rsp.done) begin
          state_d = CTL_DONE;
        end
      end
      CTL_DONE: begin
        if (out_load) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // Outputs: handshake, stack RAM ports, arithmetic start
  always_comb begin
    in_ready_o    = (state_q == CTL_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = count_q[ADDR_W-1:0];
    mem_wdata     = in_req_i.value;
    mem_raddr     = (state_q == CTL_RD_TOP) ? top_addr : next_addr;
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    case (state_q)
      CTL_IDLE: begin
        mem_we = in_acc && (in_req_i.operation == OP_PUSH) && !full;
      end
      CTL_EXEC: begin
        alu_req.start = !(op_q == OP_DIV && b_q == '0);
      end
      CTL_WAIT: begin
        mem_we    = alu_rsp.done;
        mem_waddr = next_addr;
        mem_wdata = alu_rsp.result;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        CTL_IDLE: begin
          if (in_acc) begin
            case (in_req_i.operation)
              OP_PUSH:   count_q <= full ? '0 : count_q + 1'b1;
              OP_FINISH: ;
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (few) begin
                  count_q <= '0;
                end
              end
              default: count_q <= '0;
            endcase
          end
        end
        CTL_RD_NEXT: begin
          if (op_q == OP_FINISH) begin
            count_q <= '0;
          end
        end
        CTL_EXEC: begin
          if (op_q == OP_DIV && b_q == '0) begin
            count_q <= '0;
          end
        end
        CTL_WAIT: begin
          if (alu_rsp.done) begin
            count_q <= cnt_m1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
    case (state_q)
      CTL_IDLE: begin
        op_q <= in_req_i.operation;
        case (in_req_i.operation)
          OP_PUSH: begin
            res_q.is_final <= 1'b0;
            if (full) begin
              res_q.status       <= ST_FULL;
              res_q.result_value <= '0;
            end else begin
              res_q.status       <= ST_OK;
              res_q.result_value <= in_req_i.value;
            end
          end
          OP_FINISH: begin
            res_q.status       <= ST_FEW;
            res_q.is_final     <= 1'b1;
            res_q.result_value <= '0;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            res_q.status       <= ST_FEW;
            res_q.is_final     <= 1'b0;
            res_q.result_value <= '0;
          end
          default: begin
            res_q.status       <= ST_UNKNOWN;
            res_q.is_final     <= 1'b0;
            res_q.result_value <= '0;
          end
        endcase
      end
      CTL_RD_NEXT: begin
        b_q <= mem_rdata;
        if (op_q == OP_FINISH) begin
          res_q.status       <= ST_OK;
          res_q.result_value <= mem_rdata;
        end
      end
      CTL_EXEC: begin
        res_q.status <= ST_DIVZERO;
      end
      CTL_WAIT: begin
        res_q.status       <= ST_OK;
        res_q.result_value <= alu_rsp.result;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Operand stack
  pse_stack_ram u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared arithmetic unit; left operand comes straight from the RAM read
  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (mem_rdata),
    .b_i    (b_q),
    .rsp_o  (alu_rsp)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the postfix stack evaluator: directed and random token streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS  = 200;
  localparam int unsigned PHASE_ITEMS  = 220;

  // Operation codes past finish are not defined
  localparam logic [OP_W-1:0] OP_UNKNOWN_LO = OP_FINISH + 1'b1;
  localparam logic [OP_W-1:0] OP_UNKNOWN_HI = '1;

  localparam logic signed [DATA_W-1:0] Q_MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN_VAL = 32'sh8000_0000;
  localparam longint                   Q_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint                   Q_MIN     = -64'sh0000_0000_8000_0000;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pse_req_t in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pse_rsp_t out_rsp;

  // Tokens waiting to be sent and responses still owed by the block
  pse_req_t    token_queue[$];
  pse_rsp_t    expected_rsp[$];
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  // Predicted operand stack
  logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned              stack_depth = 0;

  postfix_stack_evaluator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Saturate an exact result to Q16.16 range
  function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX_VAL;
    end else if (v < Q_MIN) begin
      return Q_MIN_VAL;
    end
    return v[DATA_W-1:0];
  endfunction

  // Apply one token to the predicted stack and return the response it owes
  function automatic pse_rsp_t evaluate_token(input pse_req_t tok);
    pse_rsp_t rsp;
    longint   lhs;
    longint   rhs;
    longint   acc;
    rsp = '0;
    case (tok.operation)
      OP_PUSH: begin
        if (stack_depth >= STACK_DEPTH) begin
          stack_depth = 0;
          rsp.status  = ST_FULL;
        end else begin
          stack_mem[stack_depth] = tok.value;
          stack_depth++;
          rsp.result_value = tok.value;
        end
      end
      OP_FINISH: begin
        rsp.is_final = 1'b1;
        if (stack_depth == 0) begin
          rsp.status = ST_FEW;
        end else begin
          rsp.result_value = stack_mem[stack_depth - 1];
          stack_depth      = 0;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (stack_depth < 2) begin
          stack_depth = 0;
          rsp.status  = ST_FEW;
        end else begin
          rhs = stack_mem[stack_depth - 1];
          lhs = stack_mem[stack_depth - 2];
          if (tok.operation == OP_DIV && rhs == 0) begin
            stack_depth = 0;
            rsp.status  = ST_DIVZERO;
          end else begin
            case (tok.operation)
              OP_ADD:  acc = lhs + rhs;
              OP_SUB:  acc = lhs - rhs;
              // arithmetic shift floors toward minus infinity
              OP_MUL:  acc = (lhs * rhs) >>> 16;
              // integer divide truncates toward zero
              default: acc = (lhs <<< 16) / rhs;
            endcase
            stack_depth--;
            stack_mem[stack_depth - 1] = clamp_q(acc);
            rsp.result_value           = stack_mem[stack_depth - 1];
          end
        end
      end
      default: begin
        stack_depth = 0;
        rsp.status  = ST_UNKNOWN;
      end
    endcase
    return rsp;
  endfunction

  // Request driver: holds a token until accepted, then predicts its response
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_rsp.push_back(evaluate_token(in_req));
      end
      if (token_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_req   <= token_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Response monitor: compares each accepted response with the oldest prediction
  always @(posedge clk_i) begin : rsp_monitor
    pse_rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected response value=%h status=%0d final=%0b", $time,
                     out_rsp.result_value, out_rsp.status, out_rsp.is_final);
          end
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp.result_value !== want.result_value || out_rsp.status !== want.status ||
              out_rsp.is_final !== want.is_final) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: expected value=%h status=%0d final=%0b, got value=%h status=%0d final=%0b",
                       $time, want.result_value, want.status, want.is_final,
                       out_rsp.result_value, out_rsp.status, out_rsp.is_final);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("postfix_stack_evaluator: mismatch");
      $finish;
    end
  end

  task automatic queue_token(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
    pse_req_t tok;
    tok.operation = op;
    tok.value     = v;
    token_queue.push_back(tok);
  endtask

  // Operand mix: extremes, zero, any bit pattern, and small values
  function automatic logic signed [DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 11))
      0:       return Q_MAX_VAL;
      1:       return Q_MIN_VAL;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
    endcase
  endfunction

  // Well-formed expression ending in finish
  task automatic gen_expression(inout int unsigned queued);
    int unsigned depth;
    int unsigned len;
    int unsigned i;
    depth = 0;
    len   = $urandom_range(2, 12);
    for (i = 0; i < len; i++) begin
      if (depth < 2 || (depth < STACK_DEPTH && $urandom_range(0, 2) == 0)) begin
        queue_token(OP_PUSH, rand_operand());
        depth++;
      end else begin
        queue_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), $urandom);
        depth--;
      end
    end
    while (depth > 1 && $urandom_range(0, 3) != 0) begin
      queue_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), $urandom);
      depth--;
      len++;
    end
    queue_token(OP_FINISH, $urandom);
    queued += len + 1;
  endtask

  // Empty the stack with finish, fill it to the top, sometimes one push past it, then finish
  task automatic gen_full_stack(inout int unsigned queued);
    int unsigned n;
    int unsigned i;
    n = STACK_DEPTH + $urandom_range(0, 1);
    queue_token(OP_FINISH, $urandom);
    for (i = 0; i < n; i++) begin
      queue_token(OP_PUSH, rand_operand());
    end
    queue_token(OP_FINISH, $urandom);
    queued += n + 2;
  endtask

  // Any operation code with any value
  task automatic gen_noise(inout int unsigned queued);
    int unsigned n;
    int unsigned i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      queue_token(OP_W'($urandom_range(0, (1 << OP_W) - 1)), $urandom);
    end
    queued += n;
  endtask

  // One idling setting: queue random tokens, then let every response come back
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned queued;
    int unsigned pick;
    queued             = 0;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (queued < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_expression(queued);
      end else if (pick < 80) begin
        gen_full_stack(queued);
      end else begin
        gen_noise(queued);
      end
    end
    while (token_queue.size() > 0 || in_valid || expected_rsp.size() > 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-stack errors, saturation at both ends, divide by zero,
    // unknown operators, finish with several entries held
    queue_token(OP_FINISH, '0);
    queue_token(OP_ADD, '0);
    queue_token(OP_PUSH, Q_MAX_VAL);
    queue_token(OP_PUSH, Q_MAX_VAL);
    queue_token(OP_ADD, '0);
    queue_token(OP_PUSH, Q_MIN_VAL);
    queue_token(OP_SUB, '0);
    queue_token(OP_PUSH, Q_MIN_VAL);
    queue_token(OP_MUL, '0);
    queue_token(OP_PUSH, Q_MIN_VAL);
    queue_token(OP_MUL, '1);
    queue_token(OP_PUSH, '0);
    queue_token(OP_DIV, '0);
    queue_token(OP_PUSH, Q_MIN_VAL);
    queue_token(OP_PUSH, '1);
    queue_token(OP_DIV, '0);
    queue_token(OP_PUSH, 32'sh0003_0000);
    queue_token(OP_DIV, '0);
    queue_token(OP_PUSH, 32'sh0000_0005);
    queue_token(OP_UNKNOWN_LO, Q_MAX_VAL);
    queue_token(OP_UNKNOWN_HI, Q_MIN_VAL);
    queue_token(OP_PUSH, 32'sh0001_8000);
    queue_token(OP_PUSH, -32'sh0002_4000);
    queue_token(OP_PUSH, 32'sh0003_0000);
    queue_token(OP_FINISH, '0);

    run_phase(0, 0);
    run_phase(76, 0);
    run_phase(0, 76);
    run_phase(18, 18);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_rsp.size() > 0) begin
      error_count++;
      $display("%0t: %0d responses never arrived", $time, expected_rsp.size());
    end
    if (error_count == 0) begin
      $display("postfix_stack_evaluator: match");
    end else begin
      $display("postfix_stack_evaluator: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pse_pkg.sv
rtl/pse_stack_ram.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator.sv
verif/tb_top.sv
